>>> rtl/hss_pkg.sv
`timescale 1ns / 1ps

package hss_pkg;

   // Field widths of the item, result and register interface.
   localparam int SLOT_W     = 7;
   localparam int CHAN_W     = 7;
   localparam int FREQ_W     = 24;
   localparam int BASE_W     = 23;
   localparam int STEP_W     = 16;
   localparam int COUNT_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int LCG_W      = 32;

   // The shuffle draws its index from the upper half of the generator word.
   localparam int LCG_SAMPLE_W = 16;

   localparam logic [LCG_W-1:0] LCG_MUL = 32'h0003_43FD;
   localparam logic [LCG_W-1:0] LCG_ADD = 32'h0026_9EC3;

   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Register indexes.
   localparam csr_index_type CSR_LCG_SEED       = 3'd0;
   localparam csr_index_type CSR_CHANNEL_COUNT  = 3'd1;
   localparam csr_index_type CSR_SYNC_ENABLE    = 3'd2;
   localparam csr_index_type CSR_SYNC_CHANNEL   = 3'd3;
   localparam csr_index_type CSR_SHUFFLE_ENABLE = 3'd4;
   localparam csr_index_type CSR_BASE_FREQ_KHZ  = 3'd5;
   localparam csr_index_type CSR_STEP_KHZ       = 3'd6;

   // Register reset values.
   localparam logic [LCG_W-1:0]   RST_LCG_SEED      = 32'hDEAD_BEEF;
   localparam logic [COUNT_W-1:0] RST_CHANNEL_COUNT = 8'd80;
   localparam logic               RST_SYNC_ENABLE   = 1'b1;
   localparam logic [CHAN_W-1:0]  RST_SYNC_CHANNEL  = 7'd40;
   localparam logic               RST_SHUFFLE_EN    = 1'b1;
   localparam logic [BASE_W-1:0]  RST_BASE_FREQ_KHZ = 23'd2400400;
   localparam logic [STEP_W-1:0]  RST_STEP_KHZ      = 16'd1000;

   // Item function codes.
   localparam logic FUNC_GENERATE = 1'b0;
   localparam logic FUNC_READ     = 1'b1;

   // Result status codes.
   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NO_TABLE  = 2'd1;
   localparam status_type STATUS_BAD_SLOT  = 2'd2;
   localparam status_type STATUS_BAD_SYNC  = 2'd3;

endpackage

>>> rtl/hss_mod_unit.sv
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle, most significant first.
// The remainder is valid in the cycle that done is high and holds until the next start.
module hss_mod_unit #(
   parameter int REM_W = 7
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [hss_pkg::LCG_SAMPLE_W-1:0] dividend,
   input  logic [REM_W:0]                   divisor,
   output logic                             done,
   output logic [REM_W-1:0]                 remainder
);

   localparam int SW = hss_pkg::LCG_SAMPLE_W;
   localparam int CW = $clog2(SW);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     step_ff, step_in;
   logic [SW-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [REM_W:0]    div_ff, div_in;

   logic [REM_W:0]    trial;
   logic [REM_W:0]    diff;

   assign trial = {rem_ff, quo_ff[SW-1]};
   assign diff  = trial - div_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = (trial >= div_ff) ? diff[REM_W-1:0] : trial[REM_W-1:0];
         quo_in  = {quo_ff[SW-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == CW'(SW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/hop_sequence_shuffler_core.sv
`timescale 1ns / 1ps

// Channel   Ports                                     Direction  Moves
// request   req_valid/req_ready, req_func, req_slot   in         one item: generate or read
// response  rsp_valid/rsp_ready, rsp_status, ...      out        one result item per request
// csr       csr_we, csr_index, csr_wdata              in         register write, no wait
//
// For a read item, the hop table memory is read into its read register when the item is
// accepted, and the frequency multiply-add then fills the output register once it is free.
// A generate item writes the n channels into the table, where n is the clipped channel count, and
// then, for each of the m - 1 swaps over the m shuffled slots, steps the generator, runs the
// bit-serial remainder unit and does the two reads and two writes of the table, which has
// one read and one write port. Reset is synchronous and clears all control state; the table
// contents are undefined until the first generate. A stalled response holds only the read and
// response states: one new item, a generate too, is taken and run while an earlier result waits.
module hop_sequence_shuffler_core #(
   parameter int MAX_CHANNELS = 128
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_func,
   input  logic [hss_pkg::SLOT_W-1:0]          req_slot,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hss_pkg::STATUS_W-1:0]        rsp_status,
   output logic [hss_pkg::CHAN_W-1:0]          rsp_channel,
   output logic [hss_pkg::FREQ_W-1:0]          rsp_freq_khz,
   output logic                                rsp_is_sync,

   input  logic                                csr_we,
   input  logic [hss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   // Table address width, and width of a slot count (which can reach MAX_CHANNELS).
   localparam int AW     = $clog2(MAX_CHANNELS);
   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W  = (CNT_W > hss_pkg::COUNT_W) ? CNT_W : hss_pkg::COUNT_W;
   localparam int PROD_W = AW + hss_pkg::STEP_W;
   localparam int SUM_W  = hss_pkg::FREQ_W + 1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_FILL = 3'd2;
   localparam logic [2:0] S_LCG  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_WRI  = 3'd5;
   localparam logic [2:0] S_WRJ  = 3'd6;
   localparam logic [2:0] S_RESP = 3'd7;

   logic [2:0]                       state_ff, state_in;

   // Configuration registers.
   logic [hss_pkg::LCG_W-1:0]        seed_ff, seed_in;
   logic [hss_pkg::COUNT_W-1:0]      ccount_ff, ccount_in;
   logic                             sync_en_ff, sync_en_in;
   logic [hss_pkg::CHAN_W-1:0]       sync_ch_ff, sync_ch_in;
   logic                             shuf_en_ff, shuf_en_in;
   logic [hss_pkg::BASE_W-1:0]       base_ff, base_in;
   logic [hss_pkg::STEP_W-1:0]       step_ff, step_in;

   // What the last good generate left behind.
   logic                             table_valid_ff, table_valid_in;
   logic [CNT_W-1:0]                 slots_built_ff, slots_built_in;
   logic                             sync_built_ff, sync_built_in;
   logic [hss_pkg::LCG_W-1:0]        lcg_ff, lcg_in;

   // Working registers of the item in progress.
   logic [CNT_W-1:0]                 gen_n_ff, gen_n_in;
   logic                             gen_sync_ff, gen_sync_in;
   logic [CNT_W-1:0]                 fill_ff, fill_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [AW-1:0]                    j_ff, j_in;
   logic [AW-1:0]                    val_i_ff, val_i_in;
   logic [hss_pkg::SLOT_W-1:0]       slot_ff, slot_in;
   hss_pkg::status_type              gstat_ff, gstat_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   hss_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic [hss_pkg::CHAN_W-1:0]       rsp_channel_ff, rsp_channel_in;
   logic [hss_pkg::FREQ_W-1:0]       rsp_freq_ff, rsp_freq_in;
   logic                             rsp_is_sync_ff, rsp_is_sync_in;

   // Hop table memory: one write port, one read port with registered data.
   logic [AW-1:0]                    hop_table_ff [MAX_CHANNELS];
   logic [AW-1:0]                    mem_rdata_ff;
   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic [AW-1:0]                    mem_wdata;
   logic                             mem_re;
   logic [AW-1:0]                    mem_raddr;

   // Remainder unit.
   logic                             div_start;
   logic [AW:0]                      div_divisor;
   logic                             div_done;
   logic [AW-1:0]                    div_rem;

   logic [hss_pkg::LCG_W-1:0]        lcg_next;
   logic                             req_fire;
   logic                             out_free;
   logic [CNT_W-1:0]                 n_calc;
   logic                             sync_bad;
   logic [CNT_W-1:0]                 shuf_len;
   logic [CNT_W-1:0]                 fill_m1;
   logic [AW-1:0]                    fill_val;
   logic [AW-1:0]                    part_off;
   logic [PROD_W-1:0]                prod;
   logic [SUM_W-1:0]                 freq_sum;
   logic                             slot_in_range;

   hss_mod_unit #(
      .REM_W (AW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (lcg_next[hss_pkg::LCG_W-1 -: hss_pkg::LCG_SAMPLE_W]),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign lcg_next    = lcg_ff * hss_pkg::LCG_MUL + hss_pkg::LCG_ADD;
   assign div_divisor = (AW + 1)'(idx_ff) + 1'b1;

   // The channel count is clipped to the table depth, and the sync channel must lie below it.
   assign n_calc   = (CMP_W'(ccount_ff) > CMP_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                                                                 : CNT_W'(ccount_ff);
   assign sync_bad = sync_en_ff && (CMP_W'(sync_ch_ff) >= CMP_W'(n_calc));

   // With sync, the shuffled part starts at slot 1 and is one slot shorter.
   assign part_off = AW'(gen_sync_ff);
   assign shuf_len = gen_n_ff - CNT_W'(gen_sync_ff);

   // Initial fill: the sync channel first when sync is on, then every other channel in ascending order.
   assign fill_m1 = fill_ff - 1'b1;
   always_comb begin
      if (gen_sync_ff && (fill_ff == '0)) begin
         fill_val = AW'(sync_ch_ff);
      end else if (gen_sync_ff) begin
         fill_val = (CMP_W'(fill_m1) < CMP_W'(sync_ch_ff)) ? AW'(fill_m1) : AW'(fill_ff);
      end else begin
         fill_val = AW'(fill_ff);
      end
   end

   // Read result: frequency saturates at the top of the 24-bit range.
   assign prod          = PROD_W'(mem_rdata_ff) * PROD_W'(step_ff);
   assign freq_sum      = SUM_W'(base_ff) + SUM_W'(prod);
   assign slot_in_range = CMP_W'(slot_ff) < CMP_W'(slots_built_ff);

   always_comb begin
      state_in       = state_ff;
      seed_in        = seed_ff;
      ccount_in      = ccount_ff;
      sync_en_in     = sync_en_ff;
      sync_ch_in     = sync_ch_ff;
      shuf_en_in     = shuf_en_ff;
      base_in        = base_ff;
      step_in        = step_ff;
      table_valid_in = table_valid_ff;
      slots_built_in = slots_built_ff;
      sync_built_in  = sync_built_ff;
      lcg_in         = lcg_ff;
      gen_n_in       = gen_n_ff;
      gen_sync_in    = gen_sync_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      j_in           = j_ff;
      val_i_in       = val_i_ff;
      slot_in        = slot_ff;
      gstat_in       = gstat_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_channel_in = rsp_channel_ff;
      rsp_freq_in    = rsp_freq_ff;
      rsp_is_sync_in = rsp_is_sync_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      div_start      = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            hss_pkg::CSR_LCG_SEED:       seed_in    = csr_wdata;
            hss_pkg::CSR_CHANNEL_COUNT:  ccount_in  = csr_wdata[hss_pkg::COUNT_W-1:0];
            hss_pkg::CSR_SYNC_ENABLE:    sync_en_in = csr_wdata[0];
            hss_pkg::CSR_SYNC_CHANNEL:   sync_ch_in = csr_wdata[hss_pkg::CHAN_W-1:0];
            hss_pkg::CSR_SHUFFLE_ENABLE: shuf_en_in = csr_wdata[0];
            hss_pkg::CSR_BASE_FREQ_KHZ:  base_in    = csr_wdata[hss_pkg::BASE_W-1:0];
            hss_pkg::CSR_STEP_KHZ:       step_in    = csr_wdata[hss_pkg::STEP_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_func == hss_pkg::FUNC_READ) begin
                  slot_in   = req_slot;
                  mem_re    = 1'b1;
                  mem_raddr = AW'(req_slot);
                  state_in  = S_READ;
               end else if (sync_bad) begin
                  table_valid_in = 1'b0;
                  gstat_in       = hss_pkg::STATUS_BAD_SYNC;
                  state_in       = S_RESP;
               end else begin
                  lcg_in      = seed_ff;
                  gen_n_in    = n_calc;
                  gen_sync_in = sync_en_ff;
                  fill_in     = '0;
                  gstat_in    = hss_pkg::STATUS_OK;
                  state_in    = S_FILL;
               end
            end
         end

         S_READ: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_channel_in = '0;
               rsp_freq_in    = '0;
               rsp_is_sync_in = 1'b0;
               priority if (!table_valid_ff) begin
                  rsp_status_in = hss_pkg::STATUS_NO_TABLE;
               end else if (!slot_in_range) begin
                  rsp_status_in = hss_pkg::STATUS_BAD_SLOT;
               end else begin
                  rsp_status_in  = hss_pkg::STATUS_OK;
                  rsp_channel_in = hss_pkg::CHAN_W'(mem_rdata_ff);
                  rsp_freq_in    = freq_sum[hss_pkg::FREQ_W] ? '1
                                                             : freq_sum[hss_pkg::FREQ_W-1:0];
                  rsp_is_sync_in = sync_built_ff && (slot_ff == '0);
               end
               state_in = S_IDLE;
            end
         end

         S_FILL: begin
            if (fill_ff == gen_n_ff) begin
               if (shuf_en_ff && (shuf_len >= CNT_W'(2))) begin
                  idx_in   = AW'(shuf_len - 1'b1);
                  state_in = S_LCG;
               end else begin
                  table_valid_in = 1'b1;
                  slots_built_in = gen_n_ff;
                  sync_built_in  = gen_sync_ff;
                  state_in       = S_RESP;
               end
            end else begin
               mem_we    = 1'b1;
               mem_waddr = AW'(fill_ff);
               mem_wdata = fill_val;
               fill_in   = fill_ff + 1'b1;
            end
         end

         // Step the generator, start the remainder by i + 1 and fetch entry i.
         S_LCG: begin
            lcg_in    = lcg_next;
            div_start = 1'b1;
            mem_re    = 1'b1;
            mem_raddr = part_off + idx_ff;
            state_in  = S_DIV;
         end

         // Entry i sits in the read register; once j is known, fetch entry j.
         S_DIV: begin
            if (div_done) begin
               val_i_in  = mem_rdata_ff;
               j_in      = div_rem;
               mem_re    = 1'b1;
               mem_raddr = part_off + div_rem;
               state_in  = S_WRI;
            end
         end

         S_WRI: begin
            mem_we    = 1'b1;
            mem_waddr = part_off + idx_ff;
            mem_wdata = mem_rdata_ff;
            state_in  = S_WRJ;
         end

         // The write of entry j lands before the next fetch, so no forwarding is needed.
         S_WRJ: begin
            mem_we    = 1'b1;
            mem_waddr = part_off + j_ff;
            mem_wdata = val_i_ff;
            if (idx_ff == AW'(1)) begin
               table_valid_in = 1'b1;
               slots_built_in = gen_n_ff;
               sync_built_in  = gen_sync_ff;
               state_in       = S_RESP;
            end else begin
               idx_in   = idx_ff - 1'b1;
               state_in = S_LCG;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = gstat_ff;
               rsp_channel_in = '0;
               rsp_freq_in    = '0;
               rsp_is_sync_in = 1'b0;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hop_table_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= hop_table_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         seed_ff        <= hss_pkg::RST_LCG_SEED;
         ccount_ff      <= hss_pkg::RST_CHANNEL_COUNT;
         sync_en_ff     <= hss_pkg::RST_SYNC_ENABLE;
         sync_ch_ff     <= hss_pkg::RST_SYNC_CHANNEL;
         shuf_en_ff     <= hss_pkg::RST_SHUFFLE_EN;
         base_ff        <= hss_pkg::RST_BASE_FREQ_KHZ;
         step_ff        <= hss_pkg::RST_STEP_KHZ;
         table_valid_ff <= 1'b0;
         slots_built_ff <= '0;
         sync_built_ff  <= 1'b0;
         lcg_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seed_ff        <= seed_in;
         ccount_ff      <= ccount_in;
         sync_en_ff     <= sync_en_in;
         sync_ch_ff     <= sync_ch_in;
         shuf_en_ff     <= shuf_en_in;
         base_ff        <= base_in;
         step_ff        <= step_in;
         table_valid_ff <= table_valid_in;
         slots_built_ff <= slots_built_in;
         sync_built_ff  <= sync_built_in;
         lcg_ff         <= lcg_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      gen_n_ff       <= gen_n_in;
      gen_sync_ff    <= gen_sync_in;
      fill_ff        <= fill_in;
      idx_ff         <= idx_in;
      j_ff           <= j_in;
      val_i_ff       <= val_i_in;
      slot_ff        <= slot_in;
      gstat_ff       <= gstat_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_channel_ff <= rsp_channel_in;
      rsp_freq_ff    <= rsp_freq_in;
      rsp_is_sync_ff <= rsp_is_sync_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_channel  = rsp_channel_ff;
   assign rsp_freq_khz = rsp_freq_ff;
   assign rsp_is_sync  = rsp_is_sync_ff;

endmodule

>>> dv/tb_hop_sequence_shuffler_core.sv
`timescale 1ns / 1ps

import hss_pkg::*;

typedef struct packed {
   logic [STATUS_W-1:0] status;
   logic [CHAN_W-1:0]   channel;
   logic [FREQ_W-1:0]   freq_khz;
   logic                is_sync;
} hop_result_t;

// Keeps its own copy of the registers and of the hop plan. It predicts each result
// when the item is accepted and checks results in order.
class hop_plan_scoreboard #(int MAX_SLOTS = 128);
   logic [LCG_W-1:0]   seed;
   logic [COUNT_W-1:0] count;
   logic               sync_en;
   logic [CHAN_W-1:0]  sync_ch;
   logic               shuffle_en;
   logic [BASE_W-1:0]  base_khz;
   logic [STEP_W-1:0]  step_khz;

   logic [CHAN_W-1:0]  plan [MAX_SLOTS];
   bit                 plan_ok;
   logic [LCG_W-1:0]   lcg;
   int unsigned        built;
   bit                 sync_built;

   hop_result_t        expected_q [$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        builds;
   int unsigned        status_count [4];

   function new();
      seed       = RST_LCG_SEED;
      count      = RST_CHANNEL_COUNT;
      sync_en    = RST_SYNC_ENABLE;
      sync_ch    = RST_SYNC_CHANNEL;
      shuffle_en = RST_SHUFFLE_EN;
      base_khz   = RST_BASE_FREQ_KHZ;
      step_khz   = RST_STEP_KHZ;
      plan_ok    = 0;
      lcg        = '0;
      built      = 0;
      sync_built = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_LCG_SEED:       seed       = data[LCG_W-1:0];
         CSR_CHANNEL_COUNT:  count      = data[COUNT_W-1:0];
         CSR_SYNC_ENABLE:    sync_en    = data[0];
         CSR_SYNC_CHANNEL:   sync_ch    = data[CHAN_W-1:0];
         CSR_SHUFFLE_ENABLE: shuffle_en = data[0];
         CSR_BASE_FREQ_KHZ:  base_khz   = data[BASE_W-1:0];
         CSR_STEP_KHZ:       step_khz   = data[STEP_W-1:0];
         default: ;
      endcase
   endfunction

   // Fisher-Yates over plan[first +: len], drawing from the upper half of the LCG word.
   function void shuffle_range(int unsigned first, int unsigned len);
      int unsigned i;
      int unsigned j;
      logic [CHAN_W-1:0] held;
      if (len < 2) return;
      for (i = len - 1; i > 0; i--) begin
         lcg  = lcg * LCG_MUL + LCG_ADD;
         j    = (lcg >> LCG_SAMPLE_W) % (i + 1);
         held = plan[first + i];
         plan[first + i] = plan[first + j];
         plan[first + j] = held;
      end
   endfunction

   function hop_result_t build_plan();
      int unsigned n;
      int unsigned fill;
      int unsigned ch;
      hop_result_t r;
      r = '0;
      n = (count > MAX_SLOTS) ? MAX_SLOTS : count;
      if (sync_en && sync_ch >= n) begin
         plan_ok  = 0;
         r.status = STATUS_BAD_SYNC;
         return r;
      end
      lcg  = seed;
      fill = 0;
      if (sync_en) begin
         plan[0] = sync_ch;
         fill    = 1;
      end
      for (ch = 0; ch < n; ch++) begin
         if (!(sync_en && ch == sync_ch)) begin
            plan[fill] = ch[CHAN_W-1:0];
            fill++;
         end
      end
      if (shuffle_en)
         shuffle_range(sync_en ? 1 : 0, sync_en ? fill - 1 : fill);
      built      = n;
      sync_built = sync_en;
      plan_ok    = 1;
      r.status   = STATUS_OK;
      return r;
   endfunction

   function void note_item(logic func, logic [SLOT_W-1:0] slot);
      hop_result_t r;
      longint unsigned f;
      r = '0;
      if (func == FUNC_GENERATE) begin
         r = build_plan();
         builds++;
      end else if (!plan_ok) begin
         r.status = STATUS_NO_TABLE;
      end else if (slot >= built) begin
         r.status = STATUS_BAD_SLOT;
      end else begin
         f = longint'(base_khz) + longint'(plan[slot]) * longint'(step_khz);
         if (f > 64'hFF_FFFF) f = 64'hFF_FFFF;
         r.status   = STATUS_OK;
         r.channel  = plan[slot];
         r.freq_khz = f[FREQ_W-1:0];
         r.is_sync  = sync_built && (slot == 0);
      end
      status_count[r.status]++;
      expected_q.push_back(r);
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   function void check_result(hop_result_t got);
      hop_result_t want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: unexpected result, status %0d channel %0d freq %0d sync %0d",
                  $time, got.status, got.channel, got.freq_khz, got.is_sync);
         return;
      end
      want = expected_q.pop_front();
      checked++;
      compare_field("status", want.status, got.status);
      compare_field("channel", want.channel, got.channel);
      compare_field("freq_khz", want.freq_khz, got.freq_khz);
      compare_field("is_sync", want.is_sync, got.is_sync);
   endfunction

   function int unsigned pending();
      return expected_q.size();
   endfunction
endclass

module tb_hop_sequence_shuffler_core;

   localparam int MAX_CH      = 128;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 152;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic [SLOT_W-1:0]     req_slot;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [CHAN_W-1:0]     rsp_channel;
   logic [FREQ_W-1:0]     rsp_freq_khz;
   logic                  rsp_is_sync;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Percent of cycles in which the sender or the receiver holds back.
   int unsigned snd_idle_pct;
   int unsigned rcv_idle_pct;

   hop_plan_scoreboard #(MAX_CH) sb;

   hop_sequence_shuffler_core #(.MAX_CHANNELS(MAX_CH)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_slot     (req_slot),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_channel  (rsp_channel),
      .rsp_freq_khz (rsp_freq_khz),
      .rsp_is_sync  (rsp_is_sync),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // The receiver decides on every falling edge whether to take a result in the
   // coming cycle, so stalls land on every phase of the block's work.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Both channels are observed at the rising edge, before the block updates. A
   // result is always due to an item accepted at an earlier edge, so the order of
   // the two calls does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_status, rsp_channel, rsp_freq_khz, rsp_is_sync});
         if (req_valid && req_ready)
            sb.note_item(req_func, req_slot);
      end
   end

   // Lowers valid and waits until every predicted result has been taken. It always
   // waits on the clock before it returns, so the caller never assigns valid twice in one step.
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // Registers are only written while the block is idle. The write takes effect at the
   // next rising edge, and the model copy is updated at the falling edge that drives it.
   task automatic set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      wait_drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offers one item, with random idle cycles in front of it, and returns at the
   // falling edge after it was accepted. Valid stays high while it waits.
   task automatic push_item(logic func, logic [SLOT_W-1:0] slot);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_slot  <= slot;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Writes all seven registers for one random phase. A few phases pin the extremes:
   // the full table with the largest frequencies, a saturated channel count with zero
   // base and step, and the all-zero and all-one seeds.
   task automatic configure_phase(int p);
      int unsigned cnt;
      int unsigned eff;
      logic [CSR_DATA_W-1:0] base;
      logic [CSR_DATA_W-1:0] step;
      if (p == 0 || p == 9)
         cnt = 128;
      else if (p == 6)
         cnt = $urandom_range(255, 129);
      else if ($urandom_range(15) == 0)
         cnt = 0;
      else
         cnt = $urandom_range(24, 1);
      eff = (cnt > MAX_CH) ? MAX_CH : cnt;
      if (p == 0) begin
         base = 32'h007F_FFFF;
         step = 32'h0000_FFFF;
      end else if (p == 6) begin
         base = '0;
         step = '0;
      end else begin
         base = ($urandom_range(4) == 0) ? $urandom_range(32'h7F_FFFF)
                                         : $urandom_range(6000000);
         step = $urandom_range(65535);
      end
      set_reg(CSR_LCG_SEED, (p == 1) ? 32'h0 : (p == 2) ? 32'hFFFF_FFFF : $urandom());
      set_reg(CSR_CHANNEL_COUNT, cnt);
      set_reg(CSR_SYNC_ENABLE, $urandom_range(1));
      // Mostly a sync channel inside the plan; now and then any channel, which may lie outside it.
      if (eff > 0 && $urandom_range(99) < 85)
         set_reg(CSR_SYNC_CHANNEL, $urandom_range(eff - 1));
      else
         set_reg(CSR_SYNC_CHANNEL, $urandom_range(127));
      set_reg(CSR_SHUFFLE_ENABLE, $urandom_range(4) != 0);
      set_reg(CSR_BASE_FREQ_KHZ, base);
      set_reg(CSR_STEP_KHZ, step);
   endtask

   initial begin
      int p;
      int k;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = FUNC_READ;
      req_slot     = '0;
      rsp_ready    = 1'b0;
      csr_we       = 1'b0;
      csr_index    = CSR_LCG_SEED;
      csr_wdata    = '0;
      snd_idle_pct = 36;
      rcv_idle_pct = 50;
      sb           = new();

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. Reads before any generate find no table.
      push_item(FUNC_READ, 7'd0);
      push_item(FUNC_READ, 7'd127);
      // The reset settings: 80 channels with channel 40 held in slot 0.
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd0);
      push_item(FUNC_READ, 7'd79);
      push_item(FUNC_READ, 7'd80);
      push_item(FUNC_READ, 7'd127);
      // New spacing after the generate: the table stays, frequencies follow.
      set_reg(CSR_BASE_FREQ_KHZ, 32'h007F_FFFF);
      set_reg(CSR_STEP_KHZ, 32'h0000_FFFF);
      push_item(FUNC_READ, 7'd0);
      push_item(FUNC_READ, 7'd1);
      // A sync channel outside the plan is refused and the table is dropped.
      set_reg(CSR_SYNC_CHANNEL, 32'd127);
      push_item(FUNC_GENERATE, 7'h7F);
      push_item(FUNC_READ, 7'd5);
      // A count above the table size is clipped to the full table.
      set_reg(CSR_CHANNEL_COUNT, 32'hFFFF_FFFF);
      set_reg(CSR_SYNC_ENABLE, 32'd0);
      set_reg(CSR_LCG_SEED, 32'hFFFF_FFFF);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd127);
      push_item(FUNC_READ, 7'd0);
      // An empty plan: every read lands out of range.
      set_reg(CSR_CHANNEL_COUNT, 32'd0);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd0);
      // Plans with nothing or one entry to shuffle draw no LCG steps.
      set_reg(CSR_CHANNEL_COUNT, 32'd1);
      set_reg(CSR_SYNC_ENABLE, 32'd1);
      set_reg(CSR_SYNC_CHANNEL, 32'd0);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd0);
      set_reg(CSR_CHANNEL_COUNT, 32'd2);
      set_reg(CSR_SYNC_CHANNEL, 32'd1);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd1);
      set_reg(CSR_CHANNEL_COUNT, 32'd1);
      set_reg(CSR_SYNC_ENABLE, 32'd0);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd0);
      // Shuffle off keeps the channels in ascending order.
      set_reg(CSR_CHANNEL_COUNT, 32'd16);
      set_reg(CSR_SHUFFLE_ENABLE, 32'd0);
      set_reg(CSR_LCG_SEED, 32'd0);
      push_item(FUNC_GENERATE, 7'd0);
      push_item(FUNC_READ, 7'd15);

      // Random part. Each phase opens with a generate so that most reads hit a built
      // table; later generates rebuild it from the same settings. Most reads ask for
      // a slot inside the plan, the rest for any slot.
      for (p = 0; p < PHASES; p++) begin
         if (p == 4) begin
            snd_idle_pct = 50;
            rcv_idle_pct = 36;
         end else if (p == 8) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         configure_phase(p);
         for (k = 0; k < PHASE_ITEMS; k++) begin
            if (k == 0 || $urandom_range(99) < 3)
               push_item(FUNC_GENERATE, $urandom_range(127));
            else if (sb.built > 0 && $urandom_range(99) < 85)
               push_item(FUNC_READ, $urandom_range(sb.built - 1));
            else
               push_item(FUNC_READ, $urandom_range(127));
            // Now and then the sender holds off until the pipe is empty.
            if ($urandom_range(199) == 0) wait_drain();
         end
      end

      wait_drain();
      repeat (16) @(negedge clock);

      $display("Covered %0d items with %0d table builds; statuses ok %0d, no table %0d,",
               sb.checked, sb.builds, sb.status_count[STATUS_OK],
               sb.status_count[STATUS_NO_TABLE]);
      $display("bad slot %0d, bad sync %0d, over %0d register phases and three stall mixes.",
               sb.status_count[STATUS_BAD_SLOT], sb.status_count[STATUS_BAD_SYNC], PHASES);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: stops a run that hangs and reports a mismatch.
   initial begin
      #10ms;
      $display("Timeout with %0d results outstanding.", sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> files.f
rtl/hss_pkg.sv
rtl/hss_mod_unit.sv
rtl/hop_sequence_shuffler_core.sv
dv/tb_hop_sequence_shuffler_core.sv
